### rtl/aat_pkg.sv
// Shared types and constants for the bounding box transform.
// No dependencies; imported by the top level, aat_cfg_regs and aat_axis.
package aat_pkg;

    localparam int NUM_REGS   = 6;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_LO = 3;

    typedef logic signed [31:0] q16_t;
    typedef logic [APB_DATA_W-1:0] reg_word_t;

    typedef enum logic [2:0] {
        REG_XX_XY = 3'd0,
        REG_XZ_TX = 3'd1,
        REG_YX_YY = 3'd2,
        REG_YZ_TY = 3'd3,
        REG_ZX_ZY = 3'd4,
        REG_ZZ_TZ = 3'd5
    } reg_idx_t;

    localparam reg_word_t RESET_XX_XY = 64'h0001_0000_0000_0000;
    localparam reg_word_t RESET_XZ_TX = 64'h0000_0000_0000_0000;
    localparam reg_word_t RESET_YX_YY = 64'h0000_0000_0001_0000;
    localparam reg_word_t RESET_YZ_TY = 64'h0000_0000_0000_0000;
    localparam reg_word_t RESET_ZX_ZY = 64'h0000_0000_0000_0000;
    localparam reg_word_t RESET_ZZ_TZ = 64'h0001_0000_0000_0000;

    // One world axis: coefficients from local x, y, z and the translation.
    typedef struct packed {
        q16_t cx;
        q16_t cy;
        q16_t cz;
        q16_t t;
    } axis_coef_t;

endpackage

### rtl/aabb_affine_transform.sv
// Top level of the axis-aligned bounding box transform.
// Depends on aat_pkg, aat_cfg_regs and aat_axis.
//
// Usage:
//   A local box (six signed Q16.16 bounds) is taken at a rising edge where
//   start is high and busy is low. busy stays low: a box may be given in
//   every cycle, so the throughput is one box per clock.
//   Each box yields one world box and a saturated flag. done is high for
//   exactly one cycle with the result; the box passes the input register,
//   product register, min/max register and result register on its way to
//   the output. The receiver cannot stall the output; results leave in the
//   order the boxes came in.
//   The matrix is programmed over the APB port, one 64-bit register at
//   byte address 8*i; pready is always high. Program it only while no box
//   is in flight.
//   Reset clears the pipeline valid bits and loads the identity matrix.
module aabb_affine_transform (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  aat_pkg::q16_t                   local_min_x,
    input  aat_pkg::q16_t                   local_min_y,
    input  aat_pkg::q16_t                   local_min_z,
    input  aat_pkg::q16_t                   local_max_x,
    input  aat_pkg::q16_t                   local_max_y,
    input  aat_pkg::q16_t                   local_max_z,
    output logic                            done,
    output aat_pkg::q16_t                   world_min_x,
    output aat_pkg::q16_t                   world_min_y,
    output aat_pkg::q16_t                   world_min_z,
    output aat_pkg::q16_t                   world_max_x,
    output aat_pkg::q16_t                   world_max_y,
    output aat_pkg::q16_t                   world_max_z,
    output logic                            saturated,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aat_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [aat_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [aat_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import aat_pkg::*;

    axis_coef_t coef_x;
    axis_coef_t coef_y;
    axis_coef_t coef_z;
    q16_t       min_x_reg;
    q16_t       min_y_reg;
    q16_t       min_z_reg;
    q16_t       max_x_reg;
    q16_t       max_y_reg;
    q16_t       max_z_reg;
    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic [5:0] sat;

    assign busy       = 1'b0;
    assign valid_next = {valid_reg[2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        min_x_reg <= local_min_x;
        min_y_reg <= local_min_y;
        min_z_reg <= local_min_z;
        max_x_reg <= local_max_x;
        max_y_reg <= local_max_y;
        max_z_reg <= local_max_z;
    end

    aat_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef_x  (coef_x),
        .coef_y  (coef_y),
        .coef_z  (coef_z)
    );

    aat_axis u_axis_x (
        .clk    (clk),
        .coef   (coef_x),
        .bmin_x (min_x_reg),
        .bmin_y (min_y_reg),
        .bmin_z (min_z_reg),
        .bmax_x (max_x_reg),
        .bmax_y (max_y_reg),
        .bmax_z (max_z_reg),
        .lo     (world_min_x),
        .hi     (world_max_x),
        .sat_lo (sat[0]),
        .sat_hi (sat[1])
    );

    aat_axis u_axis_y (
        .clk    (clk),
        .coef   (coef_y),
        .bmin_x (min_x_reg),
        .bmin_y (min_y_reg),
        .bmin_z (min_z_reg),
        .bmax_x (max_x_reg),
        .bmax_y (max_y_reg),
        .bmax_z (max_z_reg),
        .lo     (world_min_y),
        .hi     (world_max_y),
        .sat_lo (sat[2]),
        .sat_hi (sat[3])
    );

    aat_axis u_axis_z (
        .clk    (clk),
        .coef   (coef_z),
        .bmin_x (min_x_reg),
        .bmin_y (min_y_reg),
        .bmin_z (min_z_reg),
        .bmax_x (max_x_reg),
        .bmax_y (max_y_reg),
        .bmax_z (max_z_reg),
        .lo     (world_min_z),
        .hi     (world_max_z),
        .sat_lo (sat[4]),
        .sat_hi (sat[5])
    );

    assign done      = valid_reg[3];
    assign saturated = |sat;

endmodule

### rtl/aat_cfg_regs.sv
// APB register file holding the 3x4 affine matrix.
// Depends on aat_pkg.
module aat_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aat_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [aat_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [aat_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output aat_pkg::axis_coef_t                 coef_x,
    output aat_pkg::axis_coef_t                 coef_y,
    output aat_pkg::axis_coef_t                 coef_z
);
    import aat_pkg::*;

    reg_word_t xx_xy_reg;
    reg_word_t xz_tx_reg;
    reg_word_t yx_yy_reg;
    reg_word_t yz_ty_reg;
    reg_word_t zx_zy_reg;
    reg_word_t zz_tz_reg;
    reg_idx_t  idx;
    logic      wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:REG_IDX_LO]);
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_xy_reg <= RESET_XX_XY;
            xz_tx_reg <= RESET_XZ_TX;
            yx_yy_reg <= RESET_YX_YY;
            yz_ty_reg <= RESET_YZ_TY;
            zx_zy_reg <= RESET_ZX_ZY;
            zz_tz_reg <= RESET_ZZ_TZ;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_XX_XY: xx_xy_reg <= pwdata;
                REG_XZ_TX: xz_tx_reg <= pwdata;
                REG_YX_YY: yx_yy_reg <= pwdata;
                REG_YZ_TY: yz_ty_reg <= pwdata;
                REG_ZX_ZY: zx_zy_reg <= pwdata;
                REG_ZZ_TZ: zz_tz_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_XX_XY: prdata = xx_xy_reg;
            REG_XZ_TX: prdata = xz_tx_reg;
            REG_YX_YY: prdata = yx_yy_reg;
            REG_YZ_TY: prdata = yz_ty_reg;
            REG_ZX_ZY: prdata = zx_zy_reg;
            REG_ZZ_TZ: prdata = zz_tz_reg;
            default:   prdata = '0;
        endcase
    end

    assign coef_x = '{cx: xx_xy_reg[63:32], cy: xx_xy_reg[31:0],
                      cz: xz_tx_reg[63:32], t:  xz_tx_reg[31:0]};
    assign coef_y = '{cx: yx_yy_reg[63:32], cy: yx_yy_reg[31:0],
                      cz: yz_ty_reg[63:32], t:  yz_ty_reg[31:0]};
    assign coef_z = '{cx: zx_zy_reg[63:32], cy: zx_zy_reg[31:0],
                      cz: zz_tz_reg[63:32], t:  zz_tz_reg[31:0]};

endmodule

### rtl/aat_axis.sv
// Datapath for one world axis: products, min/max pick, exact sum, floor, saturate.
// Three register stages; depends on aat_pkg.
module aat_axis (
    input  logic                 clk,
    input  aat_pkg::axis_coef_t  coef,
    input  aat_pkg::q16_t        bmin_x,
    input  aat_pkg::q16_t        bmin_y,
    input  aat_pkg::q16_t        bmin_z,
    input  aat_pkg::q16_t        bmax_x,
    input  aat_pkg::q16_t        bmax_y,
    input  aat_pkg::q16_t        bmax_z,
    output aat_pkg::q16_t        lo,
    output aat_pkg::q16_t        hi,
    output logic                 sat_lo,
    output logic                 sat_hi
);
    import aat_pkg::*;

    q16_t               c       [3];
    q16_t               bmin    [3];
    q16_t               bmax    [3];
    logic signed [63:0] pmin_next   [3];
    logic signed [63:0] pmax_next   [3];
    logic signed [63:0] pmin_reg    [3];
    logic signed [63:0] pmax_reg    [3];
    logic signed [63:0] pick_lo_next [3];
    logic signed [63:0] pick_hi_next [3];
    logic signed [63:0] pick_lo_reg  [3];
    logic signed [63:0] pick_hi_reg  [3];
    q16_t               t1_reg;
    q16_t               t2_reg;
    logic signed [65:0] sum_lo;
    logic signed [65:0] sum_hi;
    logic [32:0]        lo_next;
    logic [32:0]        hi_next;
    q16_t               lo_reg;
    q16_t               hi_reg;
    logic               sat_lo_reg;
    logic               sat_hi_reg;

    // {clip flag, value}
    function automatic logic [32:0] sat34(input logic signed [33:0] v);
        logic [32:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
            r = {1'b0, v[31:0]};
        else if (v[33])
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b1, 32'h7fff_ffff};
        return r;
    endfunction

    assign c[0]    = coef.cx;
    assign c[1]    = coef.cy;
    assign c[2]    = coef.cz;
    assign bmin[0] = bmin_x;
    assign bmin[1] = bmin_y;
    assign bmin[2] = bmin_z;
    assign bmax[0] = bmax_x;
    assign bmax[1] = bmax_y;
    assign bmax[2] = bmax_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pmin_next[i] = c[i] * bmin[i];
            pmax_next[i] = c[i] * bmax[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pick_lo_next[i] = (pmin_reg[i] < pmax_reg[i]) ? pmin_reg[i] : pmax_reg[i];
            pick_hi_next[i] = (pmin_reg[i] > pmax_reg[i]) ? pmin_reg[i] : pmax_reg[i];
        end
    end

    assign sum_lo = $signed({t2_reg, 16'h0000}) + pick_lo_reg[0] + pick_lo_reg[1]
                    + pick_lo_reg[2];
    assign sum_hi = $signed({t2_reg, 16'h0000}) + pick_hi_reg[0] + pick_hi_reg[1]
                    + pick_hi_reg[2];

    // arithmetic shift by 32 floors the Q32.32 sum to whole units, not Q16.16
    assign lo_next = sat34(sum_lo[65:32]);
    assign hi_next = sat34(sum_hi[65:32]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pmin_reg[i]    <= pmin_next[i];
            pmax_reg[i]    <= pmax_next[i];
            pick_lo_reg[i] <= pick_lo_next[i];
            pick_hi_reg[i] <= pick_hi_next[i];
        end
        t1_reg     <= coef.t;
        t2_reg     <= t1_reg;
        lo_reg     <= lo_next[31:0];
        hi_reg     <= hi_next[31:0];
        sat_lo_reg <= lo_next[32];
        sat_hi_reg <= hi_next[32];
    end

    assign lo     = lo_reg;
    assign hi     = hi_reg;
    assign sat_lo = sat_lo_reg;
    assign sat_hi = sat_hi_reg;

endmodule

### rtl/aat_checker.sv
// Port-level checks for aabb_affine_transform, attached by bind.
// No dependencies.
module aat_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] world_min_x,
    input logic signed [31:0] world_min_y,
    input logic signed [31:0] world_min_z,
    input logic signed [31:0] world_max_x,
    input logic signed [31:0] world_max_y,
    input logic signed [31:0] world_max_z,
    input logic               saturated
);

    // each transfer in yields a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result missing four cycles after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without matching input transfer");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (world_min_x <= world_max_x) && (world_min_y <= world_max_y)
                 && (world_min_z <= world_max_z))
        else $error("world lower bound above upper bound");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (world_min_x == 32'sh7fffffff || world_min_x == 32'sh80000000 ||
             world_min_y == 32'sh7fffffff || world_min_y == 32'sh80000000 ||
             world_min_z == 32'sh7fffffff || world_min_z == 32'sh80000000 ||
             world_max_x == 32'sh7fffffff || world_max_x == 32'sh80000000 ||
             world_max_y == 32'sh7fffffff || world_max_y == 32'sh80000000 ||
             world_max_z == 32'sh7fffffff || world_max_z == 32'sh80000000))
        else $error("saturated flag without a clipped bound");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .world_min_x (world_min_x),
    .world_min_y (world_min_y),
    .world_min_z (world_min_z),
    .world_max_x (world_max_x),
    .world_max_y (world_max_y),
    .world_max_z (world_max_z),
    .saturated   (saturated)
);
